// ===== src/lsat_pkg.sv =====
// ----------------------------------------------------------------------------
// lsat_pkg: shared types and constants of the line sensor array tracker
// Row, count and position widths, register indexes, sequencer states and the
// small row-reduction functions used by the tracker.
// ----------------------------------------------------------------------------
package lsat_pkg;

    localparam int ROW_W      = 8;   // one bit per sensor port
    localparam int SMP_W      = 10;  // sample port width
    localparam int CNT_W      = 4;   // 0..8 active sensors
    localparam int SUM_W      = 5;   // sum of indices 0..7 is at most 28
    localparam int POS_W      = 3;
    localparam int ERR_W      = 4;
    localparam int TGT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;

    typedef logic [ROW_W-1:0] t_row;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_DIV,
        ST_OUT
    } t_state;

    function automatic logic [CNT_W-1:0] row_count(input t_row row);
        logic [CNT_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < ROW_W; i++) begin
            acc = acc + CNT_W'(row[i]);
        end
        return acc;
    endfunction

    function automatic logic [SUM_W-1:0] row_index_sum(input t_row row);
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (row[i]) begin
                acc = acc + SUM_W'(i);
            end
        end
        return acc;
    endfunction

endpackage

// ===== src/lsat_hist.sv =====
// ----------------------------------------------------------------------------
// lsat_hist: ring store of past sensor rows
// One write port, one registered read port. Per-entry valid bits make rows
// that were never written read as zero right after reset.
// ----------------------------------------------------------------------------
module lsat_hist #(
    parameter int DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  lsat_pkg::t_row                      i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output lsat_pkg::t_row                      o_rdata
);

    lsat_pkg::t_row r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    lsat_pkg::t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lsat_div.sv =====
// ----------------------------------------------------------------------------
// lsat_div: small restoring divider for the mean sensor index
// One quotient bit per cycle. The quotient is known to fit in
// three bits since the mean index never exceeds the largest index.
// ----------------------------------------------------------------------------
module lsat_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lsat_pkg::SUM_W-1:0]  i_dividend,
    input  logic [lsat_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [lsat_pkg::POS_W-1:0]  o_quotient
);

    localparam int SH_W = lsat_pkg::CNT_W + lsat_pkg::POS_W;

    logic                       r_busy;
    logic                       r_done;
    logic [1:0]                 r_k;
    logic [lsat_pkg::SUM_W-1:0] r_rem;
    logic [lsat_pkg::CNT_W-1:0] r_div;
    logic [lsat_pkg::POS_W-1:0] r_quo;

    logic [SH_W-1:0] w_trial;
    logic            w_fit;

    assign w_trial = SH_W'(r_div) << r_k;
    assign w_fit   = SH_W'(r_rem) >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == 2'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_quo <= '0;
            r_k   <= 2'd2;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem        <= r_rem - w_trial[lsat_pkg::SUM_W-1:0];
                r_quo[r_k]   <= 1'b1;
            end
            r_k <= r_k - 2'd1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/line_sensor_array_tracker.sv =====
// ----------------------------------------------------------------------------
// line_sensor_array_tracker: reflectance line-sensor position tracker
// Thresholds one sample per sensor into a bit row, keeps a ring of past rows
// and reports the delayed row's active count, mean index and error to target,
// plus the mask of sensors active in every row of the window.
// ----------------------------------------------------------------------------
// An item is one set of sensor samples; each item gives exactly one result.
// Work per item is serial: after the row is stored, the history ring is read
// back one row per cycle through its single read port, then the mean index
// is formed by a three-step restoring divider. The divider is skipped when
// the delayed row is empty, and the read-back is skipped at window zero;
// window lies between 0 and HISTORY_DEPTH. A new item is taken while the
// previous result still waits at the output. The history is marked empty at
// reset by per-row valid bits, so no clearing pass is needed. Configuration
// writes take effect at once and belong in idle time.
// ----------------------------------------------------------------------------
module line_sensor_array_tracker #(
    parameter int NUM_SENSORS   = 8,
    parameter int HISTORY_DEPTH = 8,
    parameter int SAMPLE_BITS   = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lsat_pkg::SMP_W-1:0]       i_sample_0,
    input  logic [lsat_pkg::SMP_W-1:0]       i_sample_1,
    input  logic [lsat_pkg::SMP_W-1:0]       i_sample_2,
    input  logic [lsat_pkg::SMP_W-1:0]       i_sample_3,
    input  logic [lsat_pkg::SMP_W-1:0]       i_sample_4,
    input  logic [lsat_pkg::SMP_W-1:0]       i_sample_5,
    input  logic [lsat_pkg::SMP_W-1:0]       i_sample_6,
    input  logic [lsat_pkg::SMP_W-1:0]       i_sample_7,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lsat_pkg::POS_W-1:0]       o_position,
    output logic signed [lsat_pkg::ERR_W-1:0] o_position_error,
    output logic [lsat_pkg::CNT_W-1:0]       o_active_count,
    output logic                             o_position_valid,
    output logic [lsat_pkg::ROW_W-1:0]       o_streak_mask,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [lsat_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lsat_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int WIN_W = ($clog2(HISTORY_DEPTH + 1) > 4) ? $clog2(HISTORY_DEPTH + 1) : 4;
    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(HISTORY_DEPTH);
    localparam logic [AW-1:0]    LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam lsat_pkg::t_row   SENS_MASK = lsat_pkg::ROW_W'((1 << NUM_SENSORS) - 1);
    localparam logic [lsat_pkg::SMP_W-1:0] SMP_MASK =
        lsat_pkg::SMP_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [lsat_pkg::TGT_W-1:0] TGT_RESET =
        lsat_pkg::TGT_W'((NUM_SENSORS - 1) / 2);
    localparam int SUM_CHECK = lsat_pkg::SUM_W + lsat_pkg::CNT_W;

    // configuration registers
    logic [lsat_pkg::SMP_W-1:0] r_threshold;
    logic [lsat_pkg::TGT_W-1:0] r_target;
    logic [WIN_W-1:0]           r_window;

    // sequencer and datapath
    lsat_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_slot;
    logic [AW-1:0]    r_rd_ptr;
    logic [WIN_W-1:0] r_cnt;
    logic             r_pend;
    logic             r_last;
    lsat_pkg::t_row   r_streak;
    lsat_pkg::t_row   r_delayed;
    logic [lsat_pkg::CNT_W-1:0] r_count;
    logic [lsat_pkg::POS_W-1:0] r_pos;

    // output register
    logic                       r_out_valid;
    logic [lsat_pkg::POS_W-1:0] r_o_pos;
    logic [lsat_pkg::ERR_W-1:0] r_o_err;
    logic [lsat_pkg::CNT_W-1:0] r_o_cnt;
    logic                       r_o_pvld;
    lsat_pkg::t_row             r_o_streak;

    logic [lsat_pkg::SMP_W-1:0] w_smp [lsat_pkg::ROW_W];
    lsat_pkg::t_row             w_row;
    lsat_pkg::t_row             w_rdata;
    logic                       w_accept;
    logic                       w_issue;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [lsat_pkg::POS_W-1:0] w_quo;
    logic [lsat_pkg::CNT_W-1:0] w_cnt;
    logic [lsat_pkg::SUM_W-1:0] w_sum;
    logic                       w_out_load;
    logic [WIN_W-1:0]           w_win_wr;

    assign w_smp[0] = i_sample_0;
    assign w_smp[1] = i_sample_1;
    assign w_smp[2] = i_sample_2;
    assign w_smp[3] = i_sample_3;
    assign w_smp[4] = i_sample_4;
    assign w_smp[5] = i_sample_5;
    assign w_smp[6] = i_sample_6;
    assign w_smp[7] = i_sample_7;

    always_comb begin
        for (int i = 0; i < lsat_pkg::ROW_W; i++) begin
            w_row[i] = SENS_MASK[i] && ((w_smp[i] & SMP_MASK) > r_threshold);
        end
    end

    assign o_in_ready = (r_state == lsat_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cnt      = lsat_pkg::row_count(r_delayed);
    assign w_sum      = lsat_pkg::row_index_sum(r_delayed);

    // ---------------- configuration ----------------
    assign w_win_wr = (WIN_W'(i_cfg_data[3:0]) > WIN_MAX) ? WIN_MAX : WIN_W'(i_cfg_data[3:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= lsat_pkg::SMP_W'(512);
            r_target    <= TGT_RESET;
            r_window    <= WIN_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsat_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[lsat_pkg::SMP_W-1:0];
                lsat_pkg::CFG_TARGET:    r_target    <= i_cfg_data[lsat_pkg::TGT_W-1:0];
                lsat_pkg::CFG_WINDOW:    r_window    <= w_win_wr;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsat_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_issue     = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            lsat_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (r_window == '0) ? lsat_pkg::ST_CALC : lsat_pkg::ST_SCAN;
                end
            end
            lsat_pkg::ST_SCAN: begin
                w_issue = (r_cnt < r_window);
                if (r_pend && r_last) begin
                    n_state = lsat_pkg::ST_CALC;
                end
            end
            lsat_pkg::ST_CALC: begin
                w_div_start = (w_cnt != '0);
                n_state     = (w_cnt != '0) ? lsat_pkg::ST_DIV : lsat_pkg::ST_OUT;
            end
            lsat_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = lsat_pkg::ST_OUT;
                end
            end
            lsat_pkg::ST_OUT: begin
                w_out_load = !r_out_valid || i_out_ready;
                if (w_out_load) begin
                    n_state = lsat_pkg::ST_IDLE;
                end
            end
            default: n_state = lsat_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_issue;
            if (w_accept) begin
                r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + AW'(1);
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // newest row is one step back, i.e. the slot just written
            r_rd_ptr  <= r_slot;
            r_cnt     <= '0;
            r_streak  <= SENS_MASK;
            r_delayed <= '0;
        end
        if (w_issue) begin
            r_rd_ptr <= (r_rd_ptr == '0) ? LAST_SLOT : r_rd_ptr - AW'(1);
            r_cnt    <= r_cnt + WIN_W'(1);
            r_last   <= (r_cnt + WIN_W'(1) == r_window);
        end
        if (r_state == lsat_pkg::ST_SCAN && r_pend) begin
            r_streak <= r_streak & w_rdata;
            if (r_last) begin
                r_delayed <= w_rdata & SENS_MASK;
            end
        end
        if (r_state == lsat_pkg::ST_CALC) begin
            r_count <= w_cnt;
            r_pos   <= '0;
        end
        if (w_div_done) begin
            r_pos <= w_quo;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_pos    <= r_pos;
            r_o_err    <= {1'b0, r_target} - {1'b0, r_pos};
            r_o_cnt    <= r_count;
            r_o_pvld   <= (r_count != '0);
            r_o_streak <= r_streak & SENS_MASK;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position       = r_o_pos;
    assign o_position_error = r_o_err;
    assign o_active_count   = r_o_cnt;
    assign o_position_valid = r_o_pvld;
    assign o_streak_mask    = r_o_streak;

    // ---------------- submodules ----------------
    lsat_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_accept),
        .i_waddr (r_slot),
        .i_wdata (w_row),
        .i_re    (w_issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    lsat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum),
        .i_divisor  (w_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // ---------------- assertions ----------------
    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window <= WIN_MAX)
        else $error("window register above history depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsat_pkg::ST_SCAN) |-> (r_cnt <= r_window))
        else $error("history read count ran past window");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("ready returned before item finished");

    a_empty_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_position_valid) |-> (o_position == '0 && o_active_count == '0))
        else $error("empty row reported a position");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (SUM_CHECK'(w_quo) * SUM_CHECK'(r_count) <= SUM_CHECK'(w_sum)))
        else $error("mean index exceeds index sum");

endmodule

// ===== sim/line_sensor_array_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_sensor_array_tracker_tb: self-checking bench of the line sensor tracker
// Sensor readings go in through a queued driver with random gaps. A monitor
// with random output stalls checks every result against a local tracker
// model: thresholded row ring, delayed-row count and mean, and streak mask.
// The run starts with hand-picked readings and moves on to random line
// patterns under a series of threshold, target and window settings.
// ----------------------------------------------------------------------------
module line_sensor_array_tracker_tb;

    localparam int NUM_SENS   = 8;
    localparam int HIST_DEPTH = 8;
    localparam int MAX_WAIT   = 18;
    localparam int DRAIN      = 24;    // covers the longest item, plus margin
    localparam int STALL_MAX  = 4000;
    localparam int SHOW_MAX   = 10;

    // index 3 is not a register; writes to it must be ignored
    localparam logic [lsat_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef logic [NUM_SENS-1:0][lsat_pkg::SMP_W-1:0] t_reading;

    typedef struct packed {
        logic [lsat_pkg::POS_W-1:0]        pos;
        logic signed [lsat_pkg::ERR_W-1:0] err;
        logic [lsat_pkg::CNT_W-1:0]        cnt;
        logic                              vld;
        lsat_pkg::t_row                    streak;
    } t_track;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            out_ready = 1'b0;
    t_reading                        smp       = '0;
    logic                            cfg_we    = 1'b0;
    logic [lsat_pkg::CFG_IDX_W-1:0]  cfg_idx   = lsat_pkg::CFG_THRESHOLD;
    logic [lsat_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                              in_ready;
    logic                              out_valid;
    logic [lsat_pkg::POS_W-1:0]        position;
    logic signed [lsat_pkg::ERR_W-1:0] position_error;
    logic [lsat_pkg::CNT_W-1:0]        active_count;
    logic                              position_valid;
    lsat_pkg::t_row                    streak_mask;

    // tracker model state
    lsat_pkg::t_row             hist_rows [HIST_DEPTH] = '{default: '0};
    logic [2:0]                 hist_slot = '0;
    logic [lsat_pkg::SMP_W-1:0] thr_cfg   = 10'd512;
    logic [lsat_pkg::TGT_W-1:0] tgt_cfg   = 3'd3;
    logic [3:0]                 win_cfg   = 4'd8;

    t_reading              reading_q [$];
    t_track                track_q [$];
    int                    in_gap    = 0;
    int                    out_gap   = 0;
    bit                    steady_in  = 1'b0;
    bit                    steady_out = 1'b0;
    int                    bad_cnt   = 0;
    int                    quiet_cyc = 0;
    int                    line_pos  = 3;

    always #2 clk = ~clk;

    line_sensor_array_tracker u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_sample_0       (smp[0]),
        .i_sample_1       (smp[1]),
        .i_sample_2       (smp[2]),
        .i_sample_3       (smp[3]),
        .i_sample_4       (smp[4]),
        .i_sample_5       (smp[5]),
        .i_sample_6       (smp[6]),
        .i_sample_7       (smp[7]),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_position       (position),
        .o_position_error (position_error),
        .o_active_count   (active_count),
        .o_position_valid (position_valid),
        .o_streak_mask    (streak_mask),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    // Store the thresholded row, then look back 'window' rows.
    task automatic track_reading(input t_reading r);
        lsat_pkg::t_row row;
        lsat_pkg::t_row delayed;
        lsat_pkg::t_row streak;
        logic [2:0]     idx;
        int             cnt;
        int             total;
        t_track         res;
        row = '0;
        for (int i = 0; i < NUM_SENS; i++) begin
            if (r[i] > thr_cfg) row[i] = 1'b1;
        end
        hist_rows[hist_slot] = row;
        hist_slot = hist_slot + 3'd1;
        delayed = '0;
        streak  = '1;
        if (win_cfg != 0) begin
            idx = hist_slot - win_cfg[2:0];   // window 8 wraps to the same slot
            delayed = hist_rows[idx];
            for (int k = 1; k <= win_cfg; k++) begin
                idx = hist_slot - 3'(k);
                streak &= hist_rows[idx];
            end
        end
        cnt   = 0;
        total = 0;
        for (int i = 0; i < NUM_SENS; i++) begin
            if (delayed[i]) begin
                cnt++;
                total += i;
            end
        end
        res.pos    = (cnt != 0) ? lsat_pkg::POS_W'(total / cnt) : '0;
        res.cnt    = lsat_pkg::CNT_W'(cnt);
        res.vld    = (cnt != 0);
        res.err    = lsat_pkg::ERR_W'(tgt_cfg) - lsat_pkg::ERR_W'(res.pos);
        res.streak = streak;
        track_q.push_back(res);
    endtask

    function automatic t_reading level_reading(input lsat_pkg::t_row act,
                                               input logic [lsat_pkg::SMP_W-1:0] hi,
                                               input logic [lsat_pkg::SMP_W-1:0] lo);
        t_reading r;
        for (int i = 0; i < NUM_SENS; i++) r[i] = act[i] ? hi : lo;
        return r;
    endfunction

    // Mostly a line that drifts across the array; some scattered rows and raw noise.
    function automatic t_reading make_reading(input logic [lsat_pkg::SMP_W-1:0] thr);
        t_reading       r;
        lsat_pkg::t_row act;
        int             kind;
        int             w;
        int             t;
        t    = thr;
        kind = $urandom_range(0, 19);
        if (kind < 3) begin
            for (int i = 0; i < NUM_SENS; i++) r[i] = lsat_pkg::SMP_W'($urandom_range(0, 1023));
            return r;
        end
        if (kind < 8) begin
            act = lsat_pkg::t_row'($urandom);
        end else begin
            line_pos = line_pos + $urandom_range(0, 2) - 1;
            if (line_pos < 0) line_pos = 0;
            if (line_pos > NUM_SENS - 1) line_pos = NUM_SENS - 1;
            w   = (kind == 19) ? 0 : $urandom_range(1, 3);
            act = '0;
            for (int i = 0; i < NUM_SENS; i++) begin
                if (i >= line_pos && i < line_pos + w) act[i] = 1'b1;
            end
        end
        for (int i = 0; i < NUM_SENS; i++) begin
            if (act[i] && t < 1023) begin
                r[i] = ($urandom_range(0, 7) == 0) ? lsat_pkg::SMP_W'(t + 1)
                                                   : lsat_pkg::SMP_W'($urandom_range(t + 1, 1023));
            end else begin
                r[i] = ($urandom_range(0, 7) == 0) ? thr : lsat_pkg::SMP_W'($urandom_range(0, t));
            end
        end
        return r;
    endfunction

    task automatic write_reg(input logic [lsat_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [lsat_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lsat_pkg::CFG_THRESHOLD: thr_cfg = data;
            lsat_pkg::CFG_TARGET:    tgt_cfg = data[lsat_pkg::TGT_W-1:0];
            lsat_pkg::CFG_WINDOW:
                win_cfg = (data[3:0] > HIST_DEPTH) ? 4'(HIST_DEPTH) : data[3:0];
            default: ;
        endcase
    endtask

    // Wait until every queued item is in and every result is out, then let it go quiet.
    task automatic settle();
        while (reading_q.size() != 0 || in_valid || track_q.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (in_valid && in_ready) track_reading(smp);
            if (!in_valid || in_ready) begin
                if (in_gap != 0) begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end else if (reading_q.size() != 0) begin
                    smp      <= reading_q.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 24) == 0) steady_in = !steady_in;
                    in_gap   <= steady_in ? 0 : $urandom_range(0, MAX_WAIT);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_track got;
        t_track want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end else begin
            if (out_valid && out_ready) begin
                got = '{position, position_error, active_count, position_valid, streak_mask};
                if (track_q.size() == 0) begin
                    if (bad_cnt < SHOW_MAX)
                        $display("unexpected result: pos=%0d err=%0d cnt=%0d vld=%0b mask=%h",
                                 got.pos, got.err, got.cnt, got.vld, got.streak);
                    bad_cnt++;
                end else begin
                    want = track_q.pop_front();
                    if (got.pos !== want.pos || got.err !== want.err || got.cnt !== want.cnt ||
                        got.vld !== want.vld || got.streak !== want.streak) begin
                        if (bad_cnt < SHOW_MAX) begin
                            $display("mismatch: exp pos=%0d err=%0d cnt=%0d vld=%0b mask=%h",
                                     want.pos, want.err, want.cnt, want.vld, want.streak);
                            $display("          got pos=%0d err=%0d cnt=%0d vld=%0b mask=%h",
                                     got.pos, got.err, got.cnt, got.vld, got.streak);
                        end
                        bad_cnt++;
                    end
                end
                if ($urandom_range(0, 24) == 0) steady_out = !steady_out;
                out_gap   <= steady_out ? 0 : $urandom_range(0, MAX_WAIT);
                out_ready <= steady_out;
            end else if (out_gap != 0) begin
                out_gap   <= out_gap - 1;
                out_ready <= (out_gap == 1);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog: too long with nothing moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cyc <= 0;
        end else if (quiet_cyc == STALL_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    initial begin
        int         raw_win;
        logic [9:0] thr_v;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: threshold 512, target 3, window 8; early rows read empty history
        reading_q.push_back(level_reading(8'h00, 10'd0, 10'd0));
        reading_q.push_back(level_reading(8'hFF, 10'd1023, 10'd0));
        reading_q.push_back(level_reading(8'hFF, 10'd512, 10'd0));
        reading_q.push_back(level_reading(8'hFF, 10'd513, 10'd0));
        reading_q.push_back(level_reading(8'h01, 10'd1023, 10'd0));
        reading_q.push_back(level_reading(8'h80, 10'd1023, 10'd0));
        reading_q.push_back(level_reading(8'h55, 10'd700, 10'd300));
        reading_q.push_back(level_reading(8'hAA, 10'd1023, 10'd512));
        reading_q.push_back(level_reading(8'h18, 10'd1023, 10'd0));
        reading_q.push_back(level_reading(8'h03, 10'd1023, 10'd0));
        settle();

        // one-row window, line at both ends
        write_reg(lsat_pkg::CFG_WINDOW, 10'd1);
        write_reg(lsat_pkg::CFG_TARGET, 10'd7);
        reading_q.push_back(level_reading(8'h01, 10'd1023, 10'd0));
        reading_q.push_back(level_reading(8'hC0, 10'd1023, 10'd0));
        settle();
        write_reg(lsat_pkg::CFG_TARGET, 10'd0);
        reading_q.push_back(level_reading(8'h80, 10'd1023, 10'd0));
        reading_q.push_back(level_reading(8'h00, 10'd1023, 10'd0));
        settle();

        // zero window, and a write to the unused index must change nothing
        write_reg(lsat_pkg::CFG_WINDOW, 10'd0);
        write_reg(CFG_UNUSED, 10'h3FF);
        reading_q.push_back(level_reading(8'hFF, 10'd1023, 10'd0));
        reading_q.push_back(level_reading(8'h0F, 10'd1023, 10'd0));
        settle();

        // oversized window clamps to the full depth
        write_reg(lsat_pkg::CFG_WINDOW, 10'd15);
        reading_q.push_back(level_reading(8'hFF, 10'd1023, 10'd0));
        settle();

        // threshold extremes
        write_reg(lsat_pkg::CFG_THRESHOLD, 10'd0);
        reading_q.push_back(level_reading(8'h0F, 10'd1, 10'd0));
        reading_q.push_back(level_reading(8'hF0, 10'd1, 10'd0));
        settle();
        write_reg(lsat_pkg::CFG_THRESHOLD, 10'h3FF);
        reading_q.push_back(level_reading(8'hFF, 10'd1023, 10'd1023));
        reading_q.push_back(level_reading(8'h00, 10'd0, 10'd0));
        settle();

        // random phases under changing settings
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 7))
                0:       thr_v = 10'd0;
                1:       thr_v = 10'h3FF;
                default: thr_v = 10'($urandom_range(0, 1023));
            endcase
            raw_win = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            write_reg(lsat_pkg::CFG_THRESHOLD, thr_v);
            write_reg(lsat_pkg::CFG_TARGET, 10'($urandom_range(0, 7)));
            write_reg(lsat_pkg::CFG_WINDOW, 10'(raw_win));
            for (int n = 0; n < 55; n++) reading_q.push_back(make_reading(thr_cfg));
            settle();
        end

        if (bad_cnt == 0 && track_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
